### src/bcd_rtc_alarm_countdown_timer_macros.svh
// assertion macros used by the rtc checker file
`ifndef BCD_RTC_ALARM_COUNTDOWN_TIMER_MACROS_SVH
`define BCD_RTC_ALARM_COUNTDOWN_TIMER_MACROS_SVH

// checked only while out of reset
`define BCDRTC_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// checked at every edge, reset included
`define BCDRTC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

### src/bcdrtc_pkg.sv
// types, register map and bcd helpers for the rtc
`default_nettype none
package bcdrtc_pkg;

  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_WRITE = 2'd2;

  localparam logic [3:0] REG_CTRL1    = 4'd0;
  localparam logic [3:0] REG_CTRL2    = 4'd1;
  localparam logic [3:0] REG_SECOND   = 4'd2;
  localparam logic [3:0] REG_MINUTE   = 4'd3;
  localparam logic [3:0] REG_HOUR     = 4'd4;
  localparam logic [3:0] REG_DAY      = 4'd5;
  localparam logic [3:0] REG_WEEKDAY  = 4'd6;
  localparam logic [3:0] REG_MONTH    = 4'd7;
  localparam logic [3:0] REG_YEAR     = 4'd8;
  localparam logic [3:0] REG_ALM_MIN  = 4'd9;
  localparam logic [3:0] REG_ALM_HOUR = 4'd10;
  localparam logic [3:0] REG_ALM_DAY  = 4'd11;
  localparam logic [3:0] REG_ALM_WDAY = 4'd12;
  localparam logic [3:0] REG_CLKOUT   = 4'd13;
  localparam logic [3:0] REG_TMR_CTRL = 4'd14;
  localparam logic [3:0] REG_TMR_CNT  = 4'd15;

  localparam logic [7:0] CTRL1_MASK   = 8'hA8;
  localparam logic [4:0] CTRL2_KEEP   = 5'h13;
  localparam logic [4:0] CTRL2_FLAGS  = 5'h0C;
  localparam logic [7:0] CLKOUT_MASK  = 8'h83;
  localparam logic [7:0] TMR_MASK     = 8'h83;
  localparam logic [1:0] TMR_SRC_1HZ  = 2'b10;
  localparam int         C1_STOP      = 5;
  localparam int         C2_AF        = 3;
  localparam int         C2_TF        = 2;
  localparam int         C2_AIE       = 1;
  localparam int         C2_TIE       = 0;

  localparam logic [7:0] SEC_LAST   = 8'h59;
  localparam logic [7:0] MIN_LAST   = 8'h59;
  localparam logic [7:0] HOUR_LAST  = 8'h23;
  localparam logic [7:0] MONTH_LAST = 8'h12;
  localparam logic [7:0] YEAR_LAST  = 8'h99;
  localparam logic [2:0] WDAY_LAST  = 3'd6;

  localparam logic [4:0] MON_FEB = 5'h02;
  localparam logic [4:0] MON_APR = 5'h04;
  localparam logic [4:0] MON_JUN = 5'h06;
  localparam logic [4:0] MON_SEP = 5'h09;
  localparam logic [4:0] MON_NOV = 5'h11;

  typedef struct packed {
    logic [1:0] op;
    logic [3:0] reg_addr;
    logic [7:0] write_data;
  } in_word_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       irq_active;
  } out_word_t;

  // returns {wrapped, next value}
  function automatic logic [8:0] bcd_roll(input logic [7:0] v, input logic [7:0] last,
                                          input logic [7:0] first);
    logic [8:0] r;
    logic [3:0] tens;
    tens = v[7:4] + 4'd1;
    if (v >= last) r = {1'b1, first};
    else if (v[3:0] >= 4'd9) r = {1'b0, tens, 4'h0};
    else r = {1'b0, v + 8'd1};
    return r;
  endfunction

  function automatic logic [7:0] month_len(input logic [4:0] month, input logic [7:0] year);
    logic [5:0] m4;
    logic [7:0] len;
    // year value mod 4 equals (2*tens + units) mod 4
    m4 = {1'b0, year[7:4], 1'b0} + {2'b00, year[3:0]};
    case (month)
      MON_FEB: len = (m4[1:0] == 2'b00) ? 8'h29 : 8'h28;
      MON_APR, MON_JUN, MON_SEP, MON_NOV: len = 8'h30;
      default: len = 8'h31;
    endcase
    return len;
  endfunction

  function automatic logic alarm_hit(input logic [7:0] a_min, input logic [7:0] a_hour,
                                     input logic [7:0] a_day, input logic [7:0] a_wday,
                                     input logic [6:0] minute, input logic [5:0] hour,
                                     input logic [5:0] day, input logic [2:0] wday);
    logic any_en;
    logic all_eq;
    any_en = !(a_min[7] && a_hour[7] && a_day[7] && a_wday[7]);
    all_eq = (a_min[7]  || (a_min[6:0]  == minute)) &&
             (a_hour[7] || (a_hour[5:0] == hour)) &&
             (a_day[7]  || (a_day[5:0]  == day)) &&
             (a_wday[7] || (a_wday[2:0] == wday));
    return any_en && all_eq;
  endfunction

endpackage
`default_nettype wire

### src/bcdrtc_core.sv
// register file, calendar advance, alarm and countdown timer
`default_nettype none
module bcdrtc_core
  import bcdrtc_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      en,
  input  wire in_word_t  item,
  output out_word_t      res
);

  logic [7:0] c1_r, c1_nxt;
  logic [4:0] c2_r, c2_nxt;
  logic       vl_r, vl_nxt;
  logic [6:0] sec_r, sec_nxt;
  logic [6:0] min_r, min_nxt;
  logic [5:0] hour_r, hour_nxt;
  logic [5:0] day_r, day_nxt;
  logic [2:0] wday_r, wday_nxt;
  logic [4:0] mon_r, mon_nxt;
  logic       cent_r, cent_nxt;
  logic [7:0] year_r, year_nxt;
  logic [7:0] alm_r [4];
  logic [7:0] alm_nxt [4];
  logic [7:0] clko_r, clko_nxt;
  logic [7:0] tctl_r, tctl_nxt;
  logic [7:0] tcnt_r, tcnt_nxt;
  logic [7:0] trld_r, trld_nxt;

  // calendar advance
  logic [8:0] sec_rl, min_rl, hour_rl, day_rl, mon_rl, year_rl;
  logic       c_sec, c_min, c_hour, c_day, c_mon;
  logic [6:0] sec_adv, min_adv;
  logic [5:0] hour_adv, day_adv;
  logic [2:0] wday_adv;
  logic [4:0] mon_adv;
  logic [7:0] year_adv;
  logic       cent_adv;
  logic       hit_before, hit_after;
  logic       tmr_run;
  logic [7:0] tcnt_dec;
  logic [3:0] alm_idx_full;
  logic [1:0] alm_idx;
  logic [7:0] rd;

  always_comb begin
    sec_rl   = bcd_roll({1'b0, sec_r}, SEC_LAST, 8'h00);
    min_rl   = bcd_roll({1'b0, min_r}, MIN_LAST, 8'h00);
    hour_rl  = bcd_roll({2'b00, hour_r}, HOUR_LAST, 8'h00);
    day_rl   = bcd_roll({2'b00, day_r}, month_len(mon_r, year_r), 8'h01);
    mon_rl   = bcd_roll({3'b000, mon_r}, MONTH_LAST, 8'h01);
    year_rl  = bcd_roll(year_r, YEAR_LAST, 8'h00);
    c_sec    = sec_rl[8];
    c_min    = c_sec & min_rl[8];
    c_hour   = c_min & hour_rl[8];
    c_day    = c_hour & day_rl[8];
    c_mon    = c_day & mon_rl[8];
    sec_adv  = sec_rl[6:0];
    min_adv  = c_sec ? min_rl[6:0] : min_r;
    hour_adv = c_min ? hour_rl[5:0] : hour_r;
    wday_adv = c_hour ? ((wday_r >= WDAY_LAST) ? 3'd0 : wday_r + 3'd1) : wday_r;
    day_adv  = c_hour ? day_rl[5:0] : day_r;
    mon_adv  = c_day ? mon_rl[4:0] : mon_r;
    year_adv = c_mon ? year_rl[7:0] : year_r;
    cent_adv = cent_r ^ (c_mon & year_rl[8]);
    hit_before = alarm_hit(alm_r[0], alm_r[1], alm_r[2], alm_r[3],
                           min_r, hour_r, day_r, wday_r);
    hit_after  = alarm_hit(alm_r[0], alm_r[1], alm_r[2], alm_r[3],
                           min_adv, hour_adv, day_adv, wday_adv);
  end

  assign tmr_run      = tctl_r[7] && (tctl_r[1:0] == TMR_SRC_1HZ) && (tcnt_r != 8'd0);
  assign tcnt_dec     = tcnt_r - 8'd1;
  assign alm_idx_full = item.reg_addr - REG_ALM_MIN;
  assign alm_idx      = alm_idx_full[1:0];

  always_comb begin
    case (item.reg_addr)
      REG_CTRL1:    rd = c1_r;
      REG_CTRL2:    rd = {3'b000, c2_r};
      REG_SECOND:   rd = {vl_r, sec_r};
      REG_MINUTE:   rd = {1'b0, min_r};
      REG_HOUR:     rd = {2'b00, hour_r};
      REG_DAY:      rd = {2'b00, day_r};
      REG_WEEKDAY:  rd = {5'b00000, wday_r};
      REG_MONTH:    rd = {cent_r, 2'b00, mon_r};
      REG_YEAR:     rd = year_r;
      REG_ALM_MIN:  rd = alm_r[0];
      REG_ALM_HOUR: rd = alm_r[1];
      REG_ALM_DAY:  rd = alm_r[2];
      REG_ALM_WDAY: rd = alm_r[3];
      REG_CLKOUT:   rd = clko_r;
      REG_TMR_CTRL: rd = tctl_r;
      default:      rd = tcnt_r;
    endcase
  end

  always_comb begin
    c1_nxt   = c1_r;
    c2_nxt   = c2_r;
    vl_nxt   = vl_r;
    sec_nxt  = sec_r;
    min_nxt  = min_r;
    hour_nxt = hour_r;
    day_nxt  = day_r;
    wday_nxt = wday_r;
    mon_nxt  = mon_r;
    cent_nxt = cent_r;
    year_nxt = year_r;
    alm_nxt  = alm_r;
    clko_nxt = clko_r;
    tctl_nxt = tctl_r;
    tcnt_nxt = tcnt_r;
    trld_nxt = trld_r;
    res.read_data = 8'h00;
    case (item.op)
      OP_TICK: begin
        if (!c1_r[C1_STOP]) begin
          sec_nxt  = sec_adv;
          min_nxt  = min_adv;
          hour_nxt = hour_adv;
          wday_nxt = wday_adv;
          day_nxt  = day_adv;
          mon_nxt  = mon_adv;
          year_nxt = year_adv;
          cent_nxt = cent_adv;
          if (hit_after && !hit_before) c2_nxt[C2_AF] = 1'b1;
        end
        if (tmr_run) begin
          if (tcnt_dec == 8'd0) begin
            c2_nxt[C2_TF] = 1'b1;
            tcnt_nxt = trld_r;
          end else begin
            tcnt_nxt = tcnt_dec;
          end
        end
      end
      OP_READ: res.read_data = rd;
      OP_WRITE: begin
        case (item.reg_addr)
          REG_CTRL1:  c1_nxt = item.write_data & CTRL1_MASK;
          REG_CTRL2:  c2_nxt = (item.write_data[4:0] & CTRL2_KEEP) |
                               (c2_r & item.write_data[4:0] & CTRL2_FLAGS);
          REG_SECOND: begin
            vl_nxt  = item.write_data[7];
            sec_nxt = item.write_data[6:0];
          end
          REG_MINUTE:  min_nxt  = item.write_data[6:0];
          REG_HOUR:    hour_nxt = item.write_data[5:0];
          REG_DAY:     day_nxt  = item.write_data[5:0];
          REG_WEEKDAY: wday_nxt = item.write_data[2:0];
          REG_MONTH: begin
            cent_nxt = item.write_data[7];
            mon_nxt  = item.write_data[4:0];
          end
          REG_YEAR: year_nxt = item.write_data;
          REG_ALM_MIN, REG_ALM_HOUR, REG_ALM_DAY, REG_ALM_WDAY:
            alm_nxt[alm_idx] = item.write_data;
          REG_CLKOUT:   clko_nxt = item.write_data & CLKOUT_MASK;
          REG_TMR_CTRL: tctl_nxt = item.write_data & TMR_MASK;
          default: begin
            tcnt_nxt = item.write_data;
            trld_nxt = item.write_data;
          end
        endcase
      end
      default: ;
    endcase
    res.irq_active = (c2_nxt[C2_AF] & c2_nxt[C2_AIE]) | (c2_nxt[C2_TF] & c2_nxt[C2_TIE]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c1_r   <= 8'h00;
      c2_r   <= 5'h00;
      vl_r   <= 1'b1;
      sec_r  <= 7'h00;
      min_r  <= 7'h00;
      hour_r <= 6'h00;
      day_r  <= 6'h01;
      wday_r <= 3'd0;
      mon_r  <= 5'h01;
      cent_r <= 1'b0;
      year_r <= 8'h00;
      for (int i = 0; i < 4; i++) alm_r[i] <= 8'h80;
      clko_r <= 8'h80;
      tctl_r <= 8'h03;
      tcnt_r <= 8'h00;
      trld_r <= 8'h00;
    end else if (en) begin
      c1_r   <= c1_nxt;
      c2_r   <= c2_nxt;
      vl_r   <= vl_nxt;
      sec_r  <= sec_nxt;
      min_r  <= min_nxt;
      hour_r <= hour_nxt;
      day_r  <= day_nxt;
      wday_r <= wday_nxt;
      mon_r  <= mon_nxt;
      cent_r <= cent_nxt;
      year_r <= year_nxt;
      alm_r  <= alm_nxt;
      clko_r <= clko_nxt;
      tctl_r <= tctl_nxt;
      tcnt_r <= tcnt_nxt;
      trld_r <= trld_nxt;
    end
  end

endmodule
`default_nettype wire

### src/bcd_rtc_alarm_countdown_timer.sv
// top level of the bcd real-time clock with alarm and countdown timer
//
//   port group   dir   payload      purpose
//   in_*         in    in_word_t    tick, register read or register write
//   out_*        out   out_word_t   read byte and interrupt line per word
//
// one word per cycle sustained unless the result is stalled; each word goes through
// the input register, then the register file update into the result register
// synchronous active-low reset restores the power-on register values
// a stall holds the result register and a full input register; at most two words are in flight
`default_nettype none
module bcd_rtc_alarm_countdown_timer
  import bcdrtc_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire in_word_t  in_word,
  output logic           out_valid,
  input  wire logic      out_stall,
  output out_word_t      out_word
);

  logic      in_vld_r;
  in_word_t  in_word_r;
  logic      out_vld_r;
  out_word_t out_word_r;
  out_word_t res;
  logic      go;

  assign go        = in_vld_r && (!out_vld_r || !out_stall);
  assign in_stall  = in_vld_r && out_vld_r && out_stall;
  assign out_valid = out_vld_r;
  assign out_word  = out_word_r;

  bcdrtc_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (go),
    .item  (in_word_r),
    .res   (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (!in_stall) in_vld_r <= in_valid;
      if (go) out_vld_r <= 1'b1;
      else if (!out_stall) out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) in_word_r <= in_word;
    if (go) out_word_r <= res;
  end

endmodule
`default_nettype wire

### src/bcdrtc_chk.sv
// port-level checker for the rtc top level, with its bind
`default_nettype none
`include "bcd_rtc_alarm_countdown_timer_macros.svh"
module bcdrtc_chk
  import bcdrtc_pkg::*;
(
  input wire logic      clk,
  input wire logic      rst_n,
  input wire logic      in_valid,
  input wire logic      in_stall,
  input wire in_word_t  in_word,
  input wire logic      out_valid,
  input wire logic      out_stall,
  input wire out_word_t out_word
);

  `BCDRTC_ASSERT(a_out_hold, clk, rst_n, out_valid && out_stall |=> out_valid, "result word dropped while stalled")
  `BCDRTC_ASSERT(a_out_stable, clk, rst_n, out_valid && out_stall |=> $stable(out_word), "stalled result word changed")
  `BCDRTC_ASSERT(a_in_stable, clk, rst_n, in_valid && in_stall |=> in_valid && $stable(in_word), "stalled input word changed")
  `BCDRTC_ASSERT(a_no_stall_empty, clk, rst_n, !out_valid |-> !in_stall, "input stalled with no result waiting")
  `BCDRTC_ASSERT_ALWAYS(a_reset_empty, clk, !rst_n |=> !out_valid, "result valid right after reset")

endmodule

bind bcd_rtc_alarm_countdown_timer bcdrtc_chk u_chk (.*);
`default_nettype wire
